@@ rtl/core/probe_reading_qualifier_unit_defines.svh @@
// Assertion macros for the probe reading qualifier.
// No dependencies; included by the top level.
`ifndef PROBE_READING_QUALIFIER_UNIT_DEFINES_SVH
`define PROBE_READING_QUALIFIER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define PRQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRQ_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);
`else
`define PRQ_ASSERT(label, clk, rst_n, prop, msg)
`define PRQ_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

@@ rtl/core/prq_pkg.sv @@
// Shared types and constants for the probe reading qualifier.
// No dependencies.
package prq_pkg;
  localparam int COUNT_WIDTH = 16;

  typedef enum logic [1:0] {
    LINK_OK = 2'd0, LINK_TIMEOUT = 2'd1, LINK_EXCEPTION = 2'd2, LINK_FRAME = 2'd3
  } link_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_TIMEOUT = 3'd1, ST_EXCEPTION = 3'd2, ST_FRAME = 3'd3,
    ST_IMPLAUSIBLE = 3'd4, ST_STUCK = 3'd5
  } status_t;

  localparam logic [0:0] REG_THRESHOLD = 1'b0;

  // IEEE single constants
  localparam logic [31:0] F_NEG5  = 32'hC0A0_0000;
  localparam logic [31:0] F_60    = 32'h4270_0000;
  localparam logic [31:0] F_200   = 32'h4348_0000;
  localparam logic [31:0] F_50    = 32'h4248_0000;

  typedef struct packed {
    logic [1:0]  link_status;
    logic [7:0]  exception_code;
    logic [31:0] oxygen_bits;
    logic [31:0] saturation_bits;
    logic [31:0] temperature_bits;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  exception_out;
    logic [15:0] repeat_count;
  } result_t;

  // ordered compare a < b for finite singles; -0 == +0
  function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
    logic az, bz;
    az = (a[30:0] == 31'd0);
    bz = (b[30:0] == 31'd0);
    if (az && bz) return 1'b0;
    if (a[31] != b[31]) return a[31];
    if (a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  function automatic logic flt_finite(input logic [31:0] a);
    return a[30:23] != 8'hFF;
  endfunction
endpackage

@@ rtl/core/prq_check.sv @@
// Plausibility check on the three readings: finiteness and range compares.
// Depends on prq_pkg.
module prq_check (
  input  logic [31:0] oxygen_bits,
  input  logic [31:0] saturation_bits,
  input  logic [31:0] temperature_bits,
  output logic        plausible
);
  logic fin, t_ok, s_ok, o_ok;
  always_comb begin
    fin = prq_pkg::flt_finite(oxygen_bits) && prq_pkg::flt_finite(saturation_bits)
       && prq_pkg::flt_finite(temperature_bits);
    t_ok = !prq_pkg::flt_lt(temperature_bits, prq_pkg::F_NEG5)
        && !prq_pkg::flt_lt(prq_pkg::F_60, temperature_bits);
    s_ok = !prq_pkg::flt_lt(saturation_bits, 32'h0)
        && !prq_pkg::flt_lt(prq_pkg::F_200, saturation_bits);
    o_ok = !prq_pkg::flt_lt(oxygen_bits, 32'h0)
        && !prq_pkg::flt_lt(prq_pkg::F_50, oxygen_bits);
    plausible = fin && t_ok && s_ok && o_ok;
  end
endmodule

@@ rtl/core/prq_tracker.sv @@
// Repeat tracker: previous sample, identical count and stuck decision.
// Depends on prq_pkg.
module prq_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [31:0]          oxygen_bits,
  input  logic [31:0]          temperature_bits,
  input  logic [15:0]          threshold,
  output logic [prq_pkg::COUNT_WIDTH-1:0] count_now,
  output logic [prq_pkg::COUNT_WIDTH-1:0] count_nxt,
  output logic                 stuck
);
  localparam int CW = prq_pkg::COUNT_WIDTH;
  logic          have_r;
  logic [31:0]   ox_r, tmp_r;
  logic [CW-1:0] count_r;
  logic          same;

  always_comb begin
    same = have_r && (oxygen_bits == ox_r) && (temperature_bits == tmp_r);
    if (!same) count_nxt = '0;
    else if (count_r == {CW{1'b1}}) count_nxt = count_r;
    else count_nxt = count_r + {{(CW-1){1'b0}}, 1'b1};
    stuck = 32'(count_nxt) >= 32'(threshold);
  end
  assign count_now = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      ox_r <= '0;
      tmp_r <= '0;
      count_r <= '0;
    end else if (step) begin
      have_r <= 1'b1;
      ox_r <= oxygen_bits;
      tmp_r <= temperature_bits;
      count_r <= count_nxt;
    end
  end
endmodule

@@ rtl/core/probe_reading_qualifier_unit.sv @@
// Top level of the probe reading qualifier: stream ports, APB register, result stage.
// Depends on prq_pkg, prq_check, prq_tracker and the defines header.
//  channel | direction | beat
//  in_     | slave     | tdata = link_status, exception_code, oxygen, saturation, temperature
//  out_    | master    | tdata = status, exception_out, repeat_count
//  cfg_    | APB slave | stuck_threshold at address 0
// One beat per cycle while the output is not stalled; a result is valid the cycle after
// its beat leaves the input register.
// The input is registered, then one compare-and-count pass fills the output register.
// in_tready is low only while a result waits and the input stage is also full.
// rst_n is synchronous; it clears the handshake, the threshold and the tracker.
`include "probe_reading_qualifier_unit_defines.svh"
module probe_reading_qualifier_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] link_status, [9:2] exception_code, [41:10] oxygen_bits,
  // [73:42] saturation_bits, [105:74] temperature_bits, [111:106] zero
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status, [10:3] exception_out, [26:11] repeat_count, [31:27] zero
  output logic [31:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  localparam int CW = prq_pkg::COUNT_WIDTH;
  logic [15:0]      thr_r;
  logic             iv_r, ov_r;
  prq_pkg::item_t   item_r;
  prq_pkg::result_t res_r, res_nxt;
  logic             plausible, stuck, step, advance;
  logic [CW-1:0]    count_now, count_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:1] == prq_pkg::REG_THRESHOLD) ? {16'd0, thr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= '0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
             && cfg_paddr[1:1] == prq_pkg::REG_THRESHOLD)
      thr_r <= cfg_pwdata[15:0];
  end

  // result register free, so the input stage can move on
  assign advance   = iv_r && (!ov_r || out_tready);
  assign in_tready = !iv_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) iv_r <= 1'b0;
    else if (in_tready) iv_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.link_status      <= in_tdata[1:0];
      item_r.exception_code   <= in_tdata[9:2];
      item_r.oxygen_bits      <= in_tdata[41:10];
      item_r.saturation_bits  <= in_tdata[73:42];
      item_r.temperature_bits <= in_tdata[105:74];
    end
  end

  prq_check u_check (
    .oxygen_bits(item_r.oxygen_bits), .saturation_bits(item_r.saturation_bits),
    .temperature_bits(item_r.temperature_bits), .plausible(plausible)
  );

  assign step = advance && (item_r.link_status == prq_pkg::LINK_OK) && plausible;

  prq_tracker u_tracker (
    .clk(clk), .rst_n(rst_n), .step(step),
    .oxygen_bits(item_r.oxygen_bits), .temperature_bits(item_r.temperature_bits),
    .threshold(thr_r), .count_now(count_now), .count_nxt(count_nxt), .stuck(stuck)
  );

  function automatic logic [15:0] sat16(input logic [CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    if (w > 32'h0000_FFFF) return 16'hFFFF;
    return w[15:0];
  endfunction

  always_comb begin
    res_nxt.exception_out = 8'd0;
    res_nxt.repeat_count  = sat16(count_now);
    case (item_r.link_status)
      prq_pkg::LINK_OK: begin
        if (!plausible) res_nxt.status = prq_pkg::ST_IMPLAUSIBLE;
        else begin
          res_nxt.status = stuck ? prq_pkg::ST_STUCK : prq_pkg::ST_OK;
          res_nxt.repeat_count = sat16(count_nxt);
        end
      end
      prq_pkg::LINK_TIMEOUT: res_nxt.status = prq_pkg::ST_TIMEOUT;
      prq_pkg::LINK_EXCEPTION: begin
        res_nxt.status = prq_pkg::ST_EXCEPTION;
        res_nxt.exception_out = item_r.exception_code;
      end
      default: res_nxt.status = prq_pkg::ST_FRAME;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (advance) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (advance) res_r <= res_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, res_r.repeat_count, res_r.exception_out, res_r.status};

  `PRQ_ASSERT(a_exc_zero, clk, rst_n, (out_tvalid && res_r.status != prq_pkg::ST_EXCEPTION) |-> (res_r.exception_out == 8'd0), "exception_out nonzero outside exception")
  `PRQ_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `PRQ_ASSERT(a_stuck_ok, clk, rst_n, (out_tvalid && res_r.status == prq_pkg::ST_STUCK) |-> (res_r.repeat_count >= thr_r), "stuck below threshold")
endmodule
